// File: hw/rtl/ilpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpc_pkg - shared types and constants of the IPv4 payload checksum parser
// Request and result structs, parse phases, status codes and frame offsets.
// ----------------------------------------------------------------------------
package ilpc_pkg;

  // Word limit of the payload sum
  localparam int unsigned MaxPayloadWords = 1500;
  localparam int unsigned WordCntW        = 11;

  // Field widths
  localparam int unsigned PosW = 16;
  localparam int unsigned SumW = 27;

  // Ethernet and IPv4 constants
  localparam logic [15:0] EthTypeMin   = 16'h0600;
  localparam logic [15:0] EthTypeIpv4  = 16'h0800;
  localparam logic [15:0] EthTypeCtag  = 16'h8100;
  localparam logic [15:0] EthTypeStag  = 16'h88a8;
  localparam logic [7:0]  IpProtoTcp   = 8'd6;
  localparam logic [7:0]  IpProtoUdp   = 8'd17;

  // Byte offsets within the frame
  localparam logic [PosW-1:0] PosTypeHi    = 16'd12;
  localparam logic [PosW-1:0] PosTypeLo    = 16'd13;
  localparam logic [PosW-1:0] PosTagTypeHi = 16'd16;
  localparam logic [PosW-1:0] PosTagTypeLo = 16'd17;
  localparam logic [PosW-1:0] IpStartPlain = 16'd14;
  localparam logic [PosW-1:0] IpStartTag   = 16'd18;
  localparam logic [PosW-1:0] IpProtoOfs   = 16'd9;
  localparam logic [PosW-1:0] IpLastOfs    = 16'd19;
  localparam logic [PosW-1:0] TcpLastOfs   = 16'd39;
  localparam logic [PosW-1:0] UdpLastOfs   = 16'd27;
  localparam logic [PosW-1:0] CountMax     = 16'hffff;

  typedef enum logic [2:0] {
    PH_ETH = 3'd0,
    PH_TAG = 3'd1,
    PH_IP  = 3'd2,
    PH_L4  = 3'd3,
    PH_PAY = 3'd4,
    PH_IGN = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_TCP         = 3'd0,
    ST_UDP         = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_TYPE_LOW    = 3'd3,
    ST_NOT_IPV4    = 3'd4,
    ST_OTHER_PROTO = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } req_t;

  // Result before the checksum fold
  typedef struct packed {
    status_e          status;
    logic             vlan_seen;
    logic [15:0]      payload_bytes;
    logic [SumW-1:0]  raw_sum;
  } sum_t;

  typedef struct packed {
    status_e          status;
    logic             vlan_seen;
    logic [15:0]      payload_bytes;
    logic [SumW-1:0]  raw_sum;
    logic [15:0]      folded_checksum;
  } res_t;

endpackage

// File: hw/rtl/ilpc_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpc_skid - input register with skid entry
// Holds the incoming request and keeps the upstream stall registered.
// ----------------------------------------------------------------------------
module ilpc_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ilpc_pkg::req_t in_req_i,
  input  logic           take_i,
  output logic           item_valid_o,
  output ilpc_pkg::req_t item_o
);
  import ilpc_pkg::*;

  logic a_valid_q, a_valid_d;
  logic s_valid_q, s_valid_d;
  req_t a_q, a_d;
  req_t s_q, s_d;
  logic accept;
  logic a_free;

  assign accept = in_valid_i && !s_valid_q;
  assign a_free = !a_valid_q || take_i;

  // Refill the input register from the skid entry first, then the port
  always_comb begin
    a_valid_d = a_valid_q;
    a_d       = a_q;
    s_valid_d = s_valid_q;
    s_d       = s_q;
    if (a_free) begin
      if (s_valid_q) begin
        a_valid_d = 1'b1;
        a_d       = s_q;
        s_valid_d = 1'b0;
      end else begin
        a_valid_d = accept;
        a_d       = in_req_i;
      end
    end else if (accept) begin
      s_valid_d = 1'b1;
      s_d       = in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    s_q <= s_d;
  end

  assign in_stall_o   = s_valid_q;
  assign item_valid_o = a_valid_q;
  assign item_o       = a_q;

  // A filled skid entry implies a filled input register
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_valid_q |-> a_valid_q)
    else $error("skid entry held while input register empty");

endmodule

// File: hw/rtl/ilpc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpc_parse - frame parser and payload summer
// Tracks the header phase per byte, sums payload words and registers the
// unfolded result on the final byte of each frame.
// ----------------------------------------------------------------------------
module ilpc_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic           item_valid_i,
  input  ilpc_pkg::req_t item_i,
  output logic           res_valid_o,
  output ilpc_pkg::sum_t res_o
);
  import ilpc_pkg::*;

  logic [PosW-1:0]     pos_q;
  logic [15:0]         type_q;
  logic                tag_q;
  logic [7:0]          proto_q;
  phase_e              phase_q;
  logic [SumW-1:0]     acc_q;
  logic [7:0]          held_q;
  logic                held_valid_q;
  logic [WordCntW-1:0] words_q;
  logic [15:0]         pay_cnt_q;
  logic                res_valid_q;
  sum_t                res_q;

  phase_e              phase_nxt;
  logic [15:0]         type_nxt;
  logic                tag_nxt;
  logic [7:0]          proto_nxt;
  logic [SumW-1:0]     acc_nxt;
  logic [7:0]          held_nxt;
  logic                held_valid_nxt;
  logic [WordCntW-1:0] words_nxt;
  logic [15:0]         pay_cnt_nxt;
  logic [PosW-1:0]     pos_nxt;
  sum_t                res_d;

  logic [7:0]          b;
  logic [15:0]         type_word;
  logic [PosW-1:0]     ip_base;
  logic [PosW-1:0]     l4_last;
  logic                step;
  logic                in_pay;
  logic                sum_on;
  logic [15:0]         addend;
  logic [SumW-1:0]     sum;

  assign b         = item_i.frame_byte;
  assign step      = take_i && item_valid_i;
  assign type_word = {type_q[15:8], b};
  assign ip_base   = tag_q ? IpStartTag : IpStartPlain;
  assign l4_last   = ip_base + ((proto_q == IpProtoTcp) ? TcpLastOfs : UdpLastOfs);
  assign in_pay    = (phase_q == PH_PAY);
  assign sum_on    = in_pay && (words_q < WordCntW'(MaxPayloadWords));

  // Advance the parse phase on each byte
  always_comb begin
    phase_nxt = phase_q;
    unique case (phase_q)
      PH_ETH: begin
        if (pos_q == PosTypeLo) begin
          if (type_word < EthTypeMin) begin
            phase_nxt = PH_IGN;
          end else if (type_word == EthTypeCtag || type_word == EthTypeStag) begin
            phase_nxt = PH_TAG;
          end else if (type_word == EthTypeIpv4) begin
            phase_nxt = PH_IP;
          end else begin
            phase_nxt = PH_IGN;
          end
        end
      end
      PH_TAG: begin
        if (pos_q == PosTagTypeLo) begin
          phase_nxt = (type_word == EthTypeIpv4) ? PH_IP : PH_IGN;
        end
      end
      PH_IP: begin
        if (pos_q == ip_base + IpLastOfs) begin
          phase_nxt = (proto_q == IpProtoTcp || proto_q == IpProtoUdp) ? PH_L4 : PH_IGN;
        end
      end
      PH_L4: begin
        if (pos_q == l4_last) begin
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY:  phase_nxt = PH_PAY;
      PH_IGN:  phase_nxt = PH_IGN;
      default: phase_nxt = PH_IGN;
    endcase
  end

  // Header fields, payload sum and result
  always_comb begin
    type_nxt       = type_q;
    tag_nxt        = tag_q;
    proto_nxt      = proto_q;
    held_nxt       = held_q;
    held_valid_nxt = held_valid_q;
    words_nxt      = words_q;
    pay_cnt_nxt    = pay_cnt_q;

    if ((phase_q == PH_ETH && pos_q == PosTypeHi) ||
        (phase_q == PH_TAG && pos_q == PosTagTypeHi)) begin
      type_nxt = {b, 8'h00};
    end
    if ((phase_q == PH_ETH && pos_q == PosTypeLo) ||
        (phase_q == PH_TAG && pos_q == PosTagTypeLo)) begin
      type_nxt = type_word;
    end
    if (phase_q == PH_TAG && pos_q == PosTagTypeLo) begin
      tag_nxt = 1'b1;
    end
    if (phase_q == PH_IP && pos_q == ip_base + IpProtoOfs) begin
      proto_nxt = b;
    end

    // One adder serves both the running sum and the reported sum
    if (sum_on) begin
      addend = held_valid_q ? {b, held_q} : {8'h00, b};
    end else begin
      addend = held_valid_q ? {8'h00, held_q} : 16'h0000;
    end
    sum = acc_q + SumW'(addend);

    if (in_pay && pay_cnt_q != CountMax) begin
      pay_cnt_nxt = pay_cnt_q + 16'd1;
    end
    acc_nxt = acc_q;
    if (sum_on) begin
      if (held_valid_q) begin
        acc_nxt        = sum;
        words_nxt      = words_q + WordCntW'(1);
        held_valid_nxt = 1'b0;
      end else begin
        held_nxt       = b;
        held_valid_nxt = 1'b1;
      end
    end

    pos_nxt = (pos_q != CountMax) ? pos_q + 16'd1 : pos_q;

    res_d.vlan_seen     = tag_nxt;
    res_d.payload_bytes = 16'h0000;
    res_d.raw_sum       = '0;
    if (phase_nxt == PH_PAY) begin
      res_d.status        = (proto_nxt == IpProtoTcp) ? ST_TCP : ST_UDP;
      res_d.payload_bytes = pay_cnt_nxt;
      res_d.raw_sum       = sum;
    end else if (phase_nxt == PH_IGN) begin
      if (tag_nxt) begin
        res_d.status = ST_NOT_IPV4;
      end else if (type_nxt < EthTypeMin) begin
        res_d.status = ST_TYPE_LOW;
      end else if (type_nxt != EthTypeIpv4) begin
        res_d.status = ST_NOT_IPV4;
      end else begin
        res_d.status = ST_OTHER_PROTO;
      end
    end else begin
      res_d.status = ST_TRUNCATED;
    end
  end

  // Update frame state; return to reset values after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      type_q       <= '0;
      tag_q        <= 1'b0;
      proto_q      <= '0;
      phase_q      <= PH_ETH;
      acc_q        <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      words_q      <= '0;
      pay_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (take_i) begin
        res_valid_q <= step && item_i.last_byte;
      end
      if (step) begin
        if (item_i.last_byte) begin
          pos_q        <= '0;
          type_q       <= '0;
          tag_q        <= 1'b0;
          proto_q      <= '0;
          phase_q      <= PH_ETH;
          acc_q        <= '0;
          held_q       <= '0;
          held_valid_q <= 1'b0;
          words_q      <= '0;
          pay_cnt_q    <= '0;
        end else begin
          pos_q        <= pos_nxt;
          type_q       <= type_nxt;
          tag_q        <= tag_nxt;
          proto_q      <= proto_nxt;
          phase_q      <= phase_nxt;
          acc_q        <= acc_nxt;
          held_q       <= held_nxt;
          held_valid_q <= held_valid_nxt;
          words_q      <= words_nxt;
          pay_cnt_q    <= pay_cnt_nxt;
        end
      end
    end
  end

  // Capture the result of a final byte
  always_ff @(posedge clk_i) begin
    if (step && item_i.last_byte) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A final byte taken yields exactly one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && item_i.last_byte |=> res_valid_q)
    else $error("final byte did not produce a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !(item_valid_i && item_i.last_byte) |=> !res_valid_q)
    else $error("result produced without a final byte");

  // The word count never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_q <= WordCntW'(MaxPayloadWords))
    else $error("payload word count beyond limit");

endmodule

// File: hw/rtl/ilpc_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilpc_fold - checksum fold and result register
// Folds a TCP or UDP raw sum end-around to 16 bits, complements it (zero for
// other results) and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ilpc_fold (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic           res_valid_i,
  input  ilpc_pkg::sum_t res_i,
  output logic           out_valid_o,
  output ilpc_pkg::res_t out_res_o
);
  import ilpc_pkg::*;

  logic        out_valid_q;
  res_t        out_q;
  res_t        out_d;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        summed;

  // Two end-around passes bring a 27-bit sum into 16 bits
  assign fold1  = {1'b0, res_i.raw_sum[15:0]} + 17'(res_i.raw_sum[SumW-1:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign summed = (res_i.status == ST_TCP) || (res_i.status == ST_UDP);

  always_comb begin
    out_d.status          = res_i.status;
    out_d.vlan_seen       = res_i.vlan_seen;
    out_d.payload_bytes   = res_i.payload_bytes;
    out_d.raw_sum         = res_i.raw_sum;
    out_d.folded_checksum = summed ? ~fold2 : 16'h0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_i) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Unsummed results carry no sum and no checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(out_q.status == ST_TCP || out_q.status == ST_UDP)
    |-> (out_q.raw_sum == '0) && (out_q.folded_checksum == 16'h0000))
    else $error("unsummed result carries a sum");

endmodule

// File: hw/rtl/ipv4_l4_payload_checksum_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_l4_payload_checksum_parser - IPv4 TCP/UDP payload checksum parser
// Takes an Ethernet frame one byte per request, parses an optional VLAN tag,
// a fixed IPv4 header and a fixed TCP or UDP header, and sums the payload.
// ----------------------------------------------------------------------------
// One frame byte is taken per clock while the result register is free, with
// no gaps between bytes or frames; a byte passes the input register, the
// parser and the fold stage. The rate is set by the single payload adder in
// the parser, which absorbs one byte a cycle. A result is given only for the
// final byte of each frame. The upstream stall is registered through a
// one-entry skid buffer.
module ipv4_l4_payload_checksum_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ilpc_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ilpc_pkg::res_t out_res_o
);
  import ilpc_pkg::*;

  logic take;
  logic item_valid;
  req_t item;
  logic res_valid;
  sum_t res;

  // Advance the pipeline whenever the result register is free
  assign take = !out_valid_o || !out_stall_i;

  ilpc_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ilpc_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .item_valid_i (item_valid),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ilpc_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

// File: sim/tb_ipv4_l4_payload_checksum_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_l4_payload_checksum_parser - self-checking bench of the payload parser
// Drives Ethernet frames byte by byte, tracks the parse in a local model and
// compares every frame result field by field, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_ipv4_l4_payload_checksum_parser;
  import ilpc_pkg::*;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_res_o;

  ipv4_l4_payload_checksum_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  // Generate a 4 ns clock
  always begin
    #2;
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
  end

  // Idle rates in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int fail_count      = 0;
  int results_checked = 0;
  int bytes_sent      = 0;
  int frames_sent     = 0;

  res_t       frame_results[$];
  logic [7:0] frame_buf[$];

  // Parse tracker state
  logic [15:0] trk_pos;
  logic [15:0] trk_type;
  logic        trk_tagged;
  logic [7:0]  trk_proto;
  phase_e      trk_phase;
  logic [26:0] trk_acc;
  logic [7:0]  trk_held;
  logic        trk_held_v;
  logic [10:0] trk_words;
  logic [15:0] trk_paycnt;

  task automatic clear_tracker();
    trk_pos    = '0;
    trk_type   = '0;
    trk_tagged = 1'b0;
    trk_proto  = '0;
    trk_phase  = PH_ETH;
    trk_acc    = '0;
    trk_held   = '0;
    trk_held_v = 1'b0;
    trk_words  = '0;
    trk_paycnt = '0;
  endtask

  // Advance the parse by one byte; queue the frame result on the final byte
  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [15:0] ip_start;
    logic [15:0] l4_end;
    logic [26:0] sum;
    int unsigned fold;
    res_t        res;
    ip_start = trk_tagged ? IpStartTag : IpStartPlain;
    l4_end   = ip_start + 16'd19 + ((trk_proto == IpProtoTcp) ? 16'd20 : 16'd8);
    case (trk_phase)
      PH_ETH: begin
        if (trk_pos == PosTypeHi) begin
          trk_type = {b, 8'h00};
        end else if (trk_pos == PosTypeLo) begin
          trk_type = {trk_type[15:8], b};
          if (trk_type < EthTypeMin) trk_phase = PH_IGN;
          else if (trk_type == EthTypeCtag || trk_type == EthTypeStag) trk_phase = PH_TAG;
          else if (trk_type == EthTypeIpv4) trk_phase = PH_IP;
          else trk_phase = PH_IGN;
        end
      end
      PH_TAG: begin
        if (trk_pos == PosTagTypeHi) begin
          trk_type = {b, 8'h00};
        end else if (trk_pos == PosTagTypeLo) begin
          trk_type   = {trk_type[15:8], b};
          trk_tagged = 1'b1;
          trk_phase  = (trk_type == EthTypeIpv4) ? PH_IP : PH_IGN;
        end
      end
      PH_IP: begin
        if (trk_pos == ip_start + IpProtoOfs) begin
          trk_proto = b;
        end else if (trk_pos == ip_start + IpLastOfs) begin
          trk_phase = (trk_proto == IpProtoTcp || trk_proto == IpProtoUdp) ? PH_L4 : PH_IGN;
        end
      end
      PH_L4: begin
        if (trk_pos == l4_end) trk_phase = PH_PAY;
      end
      PH_PAY: begin
        if (trk_paycnt != CountMax) trk_paycnt++;
        // Pair bytes into words, first byte low, up to the word limit
        if (trk_words < MaxPayloadWords) begin
          if (trk_held_v) begin
            trk_acc    = trk_acc + {11'd0, b, trk_held};
            trk_words  = trk_words + 11'd1;
            trk_held_v = 1'b0;
          end else begin
            trk_held   = b;
            trk_held_v = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (trk_pos != CountMax) trk_pos++;

    if (last) begin
      res           = '0;
      res.vlan_seen = trk_tagged;
      if (trk_phase == PH_PAY) begin
        res.status        = (trk_proto == IpProtoTcp) ? ST_TCP : ST_UDP;
        res.payload_bytes = trk_paycnt;
        sum               = trk_acc + (trk_held_v ? {19'd0, trk_held} : 27'd0);
        res.raw_sum       = sum;
        fold              = sum;
        while ((fold >> 16) != 0) fold = (fold & 32'hffff) + (fold >> 16);
        res.folded_checksum = ~fold[15:0];
      end else if (trk_phase == PH_IGN) begin
        if (trk_tagged) res.status = ST_NOT_IPV4;
        else if (trk_type < EthTypeMin) res.status = ST_TYPE_LOW;
        else if (trk_type != EthTypeIpv4) res.status = ST_NOT_IPV4;
        else res.status = ST_OTHER_PROTO;
      end else begin
        res.status = ST_TRUNCATED;
      end
      frame_results.push_back(res);
      clear_tracker();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Check each accepted result, then draw the next stall
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_res_o);
        fail_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("status", want.status, out_res_o.status);
        check_field("vlan_seen", want.vlan_seen, out_res_o.vlan_seen);
        check_field("payload_bytes", want.payload_bytes, out_res_o.payload_bytes);
        check_field("raw_sum", want.raw_sum, out_res_o.raw_sum);
        check_field("folded_checksum", want.folded_checksum, out_res_o.folded_checksum);
        results_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Send one byte request, idling at random first
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{frame_byte: b, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  // Send the first len bytes of the built frame, marking the final one
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i], i == len - 1);
    frames_sent++;
  endtask

  // Hold off the sender until every pending result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_results.size() != 0) @(posedge clk_i);
  endtask

  // Build a frame: addresses, type, optional tag, IPv4 header, l4 header, payload
  task automatic build_frame(input logic [15:0] outer, input logic [15:0] inner,
                             input logic [7:0] proto, input int pay_len, input int fill);
    int l4_len;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(outer[15:8]);
    frame_buf.push_back(outer[7:0]);
    if (outer == EthTypeCtag || outer == EthTypeStag) begin
      repeat (2) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(inner[15:8]);
      frame_buf.push_back(inner[7:0]);
    end
    for (int i = 0; i < 20; i++) frame_buf.push_back((i == 9) ? proto : 8'($urandom));
    l4_len = (proto == IpProtoTcp) ? 20 : 8;
    repeat (l4_len) frame_buf.push_back(8'($urandom));
    repeat (pay_len) frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic send_whole(input logic [15:0] outer, input logic [15:0] inner,
                            input logic [7:0] proto, input int pay_len, input int fill);
    build_frame(outer, inner, proto, pay_len, fill);
    send_frame(frame_buf.size());
  endtask

  task automatic test_plain_payloads();
    send_whole(EthTypeIpv4, EthTypeIpv4, IpProtoTcp, 5, -1);
    send_whole(EthTypeIpv4, EthTypeIpv4, IpProtoUdp, 0, -1);
    send_whole(EthTypeIpv4, EthTypeIpv4, IpProtoUdp, 4, 8'hff);
    send_whole(EthTypeIpv4, EthTypeIpv4, IpProtoTcp, 2, 8'h00);
  endtask

  task automatic test_vlan_tags();
    send_whole(EthTypeCtag, EthTypeIpv4, IpProtoTcp, 3, -1);
    send_whole(EthTypeStag, EthTypeIpv4, IpProtoUdp, 6, -1);
    // Inner type is never tested against the minimum type
    send_whole(EthTypeCtag, 16'h86dd, IpProtoTcp, 2, -1);
    send_whole(EthTypeStag, 16'h0000, IpProtoUdp, 2, -1);
    // A tagged frame with another protocol reports not-ipv4
    send_whole(EthTypeCtag, EthTypeIpv4, 8'd1, 2, -1);
  endtask

  task automatic test_unsummed_types();
    send_whole(16'h05ff, EthTypeIpv4, IpProtoTcp, 2, -1);
    send_whole(16'h0000, EthTypeIpv4, IpProtoTcp, 2, -1);
    send_whole(16'hffff, EthTypeIpv4, IpProtoTcp, 2, -1);
    send_whole(EthTypeMin, EthTypeIpv4, IpProtoUdp, 2, -1);
    send_whole(EthTypeIpv4, EthTypeIpv4, 8'd0, 2, -1);
    send_whole(EthTypeIpv4, EthTypeIpv4, 8'hff, 2, -1);
  endtask

  task automatic test_short_frames();
    int plain_cuts[6] = '{1, 13, 14, 33, 53, 54};
    int tag_cuts[4]   = '{15, 17, 18, 45};
    build_frame(EthTypeIpv4, EthTypeIpv4, IpProtoTcp, 0, -1);
    foreach (plain_cuts[i]) send_frame(plain_cuts[i]);
    build_frame(EthTypeCtag, EthTypeIpv4, IpProtoUdp, 0, -1);
    foreach (tag_cuts[i]) send_frame(tag_cuts[i]);
  endtask

  // Mostly well-formed frames with random content; the rest broken or noise
  task automatic send_random_frame();
    int          kind;
    int          pay_len;
    int          cut;
    logic [15:0] outer;
    logic [15:0] inner;
    logic [7:0]  proto;
    kind = $urandom_range(99);
    case ($urandom_range(2))
      0:       outer = EthTypeIpv4;
      1:       outer = EthTypeCtag;
      default: outer = EthTypeStag;
    endcase
    inner   = EthTypeIpv4;
    proto   = $urandom_range(1) ? IpProtoTcp : IpProtoUdp;
    pay_len = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(24);
    if (kind >= 70 && kind < 80) begin
      outer = 16'($urandom);
    end else if (kind >= 80 && kind < 85) begin
      outer = EthTypeCtag;
      inner = 16'($urandom);
    end else if (kind >= 85 && kind < 90) begin
      proto = 8'($urandom);
    end
    build_frame(outer, inner, proto, pay_len, -1);
    cut = (kind >= 90) ? $urandom_range(frame_buf.size(), 1) : frame_buf.size();
    send_frame(cut);
  endtask

  task automatic test_random_frames(input int byte_goal, input int frame_goal);
    int first_byte;
    int first_frame;
    first_byte  = bytes_sent;
    first_frame = frames_sent;
    while (bytes_sent - first_byte < byte_goal || frames_sent - first_frame < frame_goal)
      send_random_frame();
  endtask

  // Hard limit on the run
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clear_tracker();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles less than the receiver stalls
    send_idle_pct = 36;
    recv_idle_pct = 55;
    test_plain_payloads();
    test_vlan_tags();
    drain_results();
    test_unsummed_types();
    test_short_frames();
    drain_results();
    test_random_frames(220, 2);
    drain_results();

    // Swap the idle rates
    send_idle_pct = 55;
    recv_idle_pct = 36;
    test_random_frames(220, 2);

    // Back-to-back traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(220, 2);

    // Wait for the tail results, then keep watching for strays
    in_valid_i <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d frames in %0d bytes: plain and tagged TCP/UDP, odd payloads,",
             frames_sent, bytes_sent);
    $display("short frames, unsummed types and random traffic; %0d results checked",
             results_checked);
    if (fail_count == 0 && frame_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
